### hdl/hga_pkg.sv
`timescale 1ns / 1ps
package hga_pkg;

  localparam int CAPACITY = 1024;
  localparam int CAP_W = $clog2(CAPACITY + 1);

  localparam int CORDIC_ITERATIONS = 24;
  localparam int ITER_W = 5;              // atan table has 32 entries

  localparam int XY_W = 34;               // CORDIC x/y, Q30 with headroom
  localparam int Z_W = 32;                // CORDIC angle, 1e-7 degree
  localparam int ANG_W = 35;              // angle differences before wrapping

  localparam int MUL_W = 34;
  localparam int MUL_CW = $clog2(MUL_W);

  localparam int ROOT_W = 31;             // root bits = radicand bit pairs
  localparam int ROOT_CW = $clog2(ROOT_W);

  localparam int DIST_W = 25;
  localparam int DIV_CW = $clog2(DIST_W);
  localparam int ACC_W = 62;              // dividend width
  localparam int REM_W = ACC_W - DIST_W;  // partial remainder width

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [ANG_W-1:0] FULL_TURN = 35'sd3600000000;
  localparam logic signed [ANG_W-1:0] HALF_TURN = 35'sd1800000000;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 35'sd900000000;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic signed [MUL_W-1:0] METRE_NUM = 34'sd1111949266;
  localparam logic [ACC_W-1:0] HALF_DEN = 62'd50000000000;
  localparam logic [REM_W-1:0] METRE_DEN = 37'd100000000000;
  localparam logic [DIST_W-1:0] MAX_DIST = 25'd20015087;

  localparam logic signed [30:0] CENTER_LAT_RST = -31'sd235505000;
  localparam logic signed [31:0] CENTER_LON_RST = -32'sd466333000;
  localparam logic [DIST_W-1:0] RADIUS_RST = 25'd10000;

  localparam logic [1:0] CFG_CENTER_LAT = 2'd0;
  localparam logic [1:0] CFG_CENTER_LON = 2'd1;
  localparam logic [1:0] CFG_RADIUS = 2'd2;

  typedef struct packed {
    logic signed [30:0] point_latitude;
    logic signed [31:0] point_longitude;
  } in_word_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance_metres;
    logic              within_radius;
    logic              admitted;
    logic              store_full;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SIN_LAT,
    S_SIN_LON,
    S_COS_C,
    S_COS_P,
    S_MUL_CC,
    S_MUL_S1,
    S_MUL_S2,
    S_MUL_A,
    S_SQRT_A,
    S_SQRT_B,
    S_VEC,
    S_MUL_M,
    S_DIV,
    S_OUT
  } seq_state_t;

  // atan(2^-i) in 1e-7 degree
  function automatic logic signed [Z_W-1:0] atan_entry(input logic [ITER_W-1:0] idx);
    logic signed [Z_W-1:0] r;
    unique case (idx)
      5'd0:  r = 32'sd450000000;
      5'd1:  r = 32'sd265650512;
      5'd2:  r = 32'sd140362435;
      5'd3:  r = 32'sd71250163;
      5'd4:  r = 32'sd35763344;
      5'd5:  r = 32'sd17899106;
      5'd6:  r = 32'sd8951737;
      5'd7:  r = 32'sd4476142;
      5'd8:  r = 32'sd2238105;
      5'd9:  r = 32'sd1119057;
      5'd10: r = 32'sd559529;
      5'd11: r = 32'sd279765;
      5'd12: r = 32'sd139882;
      5'd13: r = 32'sd69941;
      5'd14: r = 32'sd34971;
      5'd15: r = 32'sd17485;
      5'd16: r = 32'sd8743;
      5'd17: r = 32'sd4371;
      5'd18: r = 32'sd2186;
      5'd19: r = 32'sd1093;
      5'd20: r = 32'sd546;
      5'd21: r = 32'sd273;
      5'd22: r = 32'sd137;
      5'd23: r = 32'sd68;
      5'd24: r = 32'sd34;
      5'd25: r = 32'sd17;
      5'd26: r = 32'sd9;
      5'd27: r = 32'sd4;
      5'd28: r = 32'sd2;
      5'd29: r = 32'sd1;
      5'd30: r = 32'sd1;
      5'd31: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

### hdl/hga_cordic.sv
`timescale 1ns / 1ps
module hga_cordic (
  input  logic                                clk,
  input  logic                                rst,
  input  hga_pkg::cordic_ctl_t                ctl,
  input  logic signed [hga_pkg::XY_W-1:0]     x_init,
  input  logic signed [hga_pkg::XY_W-1:0]     y_init,
  input  logic signed [hga_pkg::Z_W-1:0]      z_init,
  output logic                                done,
  output logic signed [hga_pkg::XY_W-1:0]     x_res,
  output logic signed [hga_pkg::XY_W-1:0]     y_res,
  output logic signed [hga_pkg::Z_W-1:0]      z_res
);
  import hga_pkg::*;

  logic                    busy;
  logic                    vec;
  logic [ITER_W-1:0]       idx;
  logic signed [XY_W-1:0]  x, y, xs, ys, x_next, y_next;
  logic signed [Z_W-1:0]   z, z_next, at;
  logic                    pos;

  // one micro-rotation per cycle, shifts floor toward minus infinity
  always_comb begin
    xs = x >>> idx;
    ys = y >>> idx;
    at = atan_entry(idx);
    pos = vec ? y[XY_W-1] : ~z[Z_W-1];
    if (pos) begin
      x_next = x - ys;
      y_next = y + xs;
      z_next = z - at;
    end else begin
      x_next = x + ys;
      y_next = y - xs;
      z_next = z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start && !busy) begin
        busy <= 1'b1;
      end else if (busy && idx == ITER_W'(CORDIC_ITERATIONS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start && !busy) begin
      x   <= x_init;
      y   <= y_init;
      z   <= z_init;
      vec <= ctl.vectoring;
      idx <= '0;
    end else if (busy) begin
      x   <= x_next;
      y   <= y_next;
      z   <= z_next;
      idx <= idx + 1'b1;
    end
  end

  assign x_res = x;
  assign y_res = y;
  assign z_res = z;

endmodule

### hdl/hga_mul.sv
`timescale 1ns / 1ps
module hga_mul (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [hga_pkg::MUL_W-1:0]   a_in,
  input  logic signed [hga_pkg::MUL_W-1:0]   b_in,
  output logic                               done,
  output logic [2*hga_pkg::MUL_W-1:0]        prod,
  output logic                               neg
);
  import hga_pkg::*;

  logic                 busy;
  logic [MUL_CW-1:0]    cnt;
  logic [MUL_W-1:0]     am, a_mag, b_mag;
  logic [2*MUL_W-1:0]   p;
  logic [MUL_W:0]       sum;

  // sign-magnitude, one multiplier bit per cycle
  always_comb begin
    a_mag = a_in[MUL_W-1] ? MUL_W'(-a_in) : MUL_W'(a_in);
    b_mag = b_in[MUL_W-1] ? MUL_W'(-b_in) : MUL_W'(b_in);
    sum = {1'b0, p[2*MUL_W-1:MUL_W]} + {1'b0, (p[0] ? am : '0)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
      end else if (busy && cnt == MUL_CW'(MUL_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      am  <= a_mag;
      neg <= a_in[MUL_W-1] ^ b_in[MUL_W-1];
      p   <= {{MUL_W{1'b0}}, b_mag};
      cnt <= '0;
    end else if (busy) begin
      p   <= {sum, p[MUL_W-1:1]};
      cnt <= cnt + 1'b1;
    end
  end

  assign prod = p;

endmodule

### hdl/hga_sqrt.sv
`timescale 1ns / 1ps
module hga_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [hga_pkg::ROOT_W-1:0]    rad,
  output logic                          done,
  output logic [hga_pkg::ROOT_W-1:0]    root
);
  import hga_pkg::*;

  logic                  busy;
  logic [ROOT_CW-1:0]    cnt;
  logic [2*ROOT_W-1:0]   sr;
  logic [ROOT_W+2:0]     rem, rem_sh, trial;
  logic                  ge;

  // radicand is rad * 2^30, two bits consumed per cycle
  always_comb begin
    rem_sh = {rem[ROOT_W:0], sr[2*ROOT_W-1:2*ROOT_W-2]};
    trial  = {1'b0, root, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
      end else if (busy && cnt == ROOT_CW'(ROOT_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      sr   <= {1'b0, rad, {(ROOT_W-1){1'b0}}};
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (busy) begin
      sr   <= {sr[2*ROOT_W-3:0], 2'b00};
      rem  <= ge ? (rem_sh - trial) : rem_sh;
      root <= {root[ROOT_W-2:0], ge};
      cnt  <= cnt + 1'b1;
    end
  end

endmodule

### hdl/hga_div.sv
`timescale 1ns / 1ps
module hga_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [hga_pkg::ACC_W-1:0]     dividend,
  output logic                          done,
  output logic [hga_pkg::DIST_W-1:0]    quot
);
  import hga_pkg::*;

  logic                 busy;
  logic [DIV_CW-1:0]    cnt;
  logic [REM_W-1:0]     rem;
  logic [REM_W:0]       rem_sh, diff;
  logic                 ge;

  // restoring division by the metre constant, one quotient bit per cycle;
  // quotient bits enter quot from the bottom as dividend bits leave the top
  always_comb begin
    rem_sh = {rem, quot[DIST_W-1]};
    diff   = rem_sh - {1'b0, METRE_DEN};
    ge     = rem_sh >= {1'b0, METRE_DEN};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CW'(DIST_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      rem  <= dividend[ACC_W-1:DIST_W];
      quot <= dividend[DIST_W-1:0];
      cnt  <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      quot <= {quot[DIST_W-2:0], ge};
      cnt  <= cnt + 1'b1;
    end
  end

endmodule

### hdl/haversine_geofence_admit_top.sv
`timescale 1ns / 1ps
// Haversine geofence admission.
// Input channel (in_valid / in_stall / in_data) takes one report position,
// latitude and longitude in 1e-7 degree. Output channel (out_valid /
// out_stall / out_data) returns one word per report: distance to the centre
// in metres, within-radius flag, admitted flag and store-full flag.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the
// centre latitude, centre longitude and radius; cfg_ready is always high.
// Write config only while no report is in flight.
// One report at a time, computed by the serial units: four CORDIC
// rotations, five bit-serial multiplies, two digit-serial square roots,
// one CORDIC vectoring pass and a divider, each launched and awaited
// through its start/done handshake.
// in_stall is low only while the sequencer is idle. A finished word sits in
// the output register; the next report can be accepted and computed while
// it waits, and the sequencer holds its own result until the slot frees.
// Reset (rst, synchronous) loads default config, clears the admitted count
// and empties the output register.
module haversine_geofence_admit_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  hga_pkg::in_word_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output hga_pkg::out_word_t   out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data
);
  import hga_pkg::*;

  typedef struct packed {
    logic                  neg;
    logic signed [Z_W-1:0] ang;
  } fold_t;

  // config
  logic signed [30:0]    clat;
  logic signed [31:0]    clon;
  logic [DIST_W-1:0]     radius;

  // sequencer
  seq_state_t            state, state_next, succ;
  logic                  launched, launched_next;
  logic [CAP_W-1:0]      admitted_count;
  logic                  out_load;

  // captured report and intermediates
  logic signed [30:0]    plat;
  logic signed [31:0]    plon;
  logic signed [XY_W-1:0] s1, s2, c1, c2, cc, s1sq, s2sq;
  logic [30:0]           a_val, a_next;
  logic [ROOT_W-1:0]     sa, sb;
  logic [30:0]           ang, ang_next;
  logic [ACC_W-1:0]      dividend;
  logic [DIST_W-1:0]     dist_m;

  // unit hookups
  cordic_ctl_t            cordic_ctl;
  logic signed [XY_W-1:0] cx_init, cy_init, cx_res, cy_res;
  logic signed [Z_W-1:0]  cz_init, cz_res;
  logic                   cordic_done;
  logic                   mul_start, mul_done, mul_neg;
  logic signed [MUL_W-1:0] ma, mb;
  logic [2*MUL_W-1:0]     mul_prod;
  logic                   sqrt_start, sqrt_done;
  logic [ROOT_W-1:0]      sqrt_rad, sqrt_root;
  logic                   div_start, div_done;
  logic [DIST_W-1:0]      div_quot;

  // derived angles
  logic signed [ANG_W-1:0] dlat, dlon;
  logic signed [Z_W-1:0]   z_lat_half, z_lon_half;
  fold_t                   fold_c, fold_p;

  // product scaled by 2^-30, floor
  logic [38:0]           qa;
  logic signed [38:0]    r30, asum;
  logic signed [ANG_W-1:0] zz;
  logic [ANG_W-1:0]      zc;

  // wrap to (-180, 180], then halve truncating toward zero
  function automatic logic signed [Z_W-1:0] wrap_half(input logic signed [ANG_W-1:0] d);
    logic signed [ANG_W-1:0] w, h;
    w = d;
    if (d > HALF_TURN) begin
      w = d - FULL_TURN;
    end else if (d <= -HALF_TURN) begin
      w = d + FULL_TURN;
    end
    h = w + $signed({{(ANG_W-1){1'b0}}, w[ANG_W-1]});
    return h[Z_W:1];
  endfunction

  // fold latitude into [-90, 90], cosine sign flips
  function automatic fold_t fold_lat(input logic signed [30:0] t);
    logic signed [ANG_W-1:0] tt, r;
    fold_t f;
    tt = {{(ANG_W-31){t[30]}}, t};
    r = tt;
    f.neg = 1'b0;
    if (tt > QUARTER_TURN) begin
      r = HALF_TURN - tt;
      f.neg = 1'b1;
    end else if (tt < -QUARTER_TURN) begin
      r = -HALF_TURN - tt;
      f.neg = 1'b1;
    end
    f.ang = r[Z_W-1:0];
    return f;
  endfunction

  always_comb begin
    dlat = {{(ANG_W-31){plat[30]}}, plat} - {{(ANG_W-31){clat[30]}}, clat};
    dlon = {{(ANG_W-32){plon[31]}}, plon} - {{(ANG_W-32){clon[31]}}, clon};
    z_lat_half = wrap_half(dlat);
    z_lon_half = wrap_half(dlon);
    fold_c = fold_lat(clat);
    fold_p = fold_lat(plat);
  end

  // asr by 30 of a sign-magnitude product
  always_comb begin
    qa = {1'b0, mul_prod[2*MUL_W-1:30]} +
         39'(mul_neg & (|mul_prod[29:0]));
    r30 = mul_neg ? -$signed(qa) : $signed(qa);
    asum = $signed({{(39-XY_W){s1sq[XY_W-1]}}, s1sq}) + r30;
    if (asum[38]) begin
      a_next = '0;
    end else if (asum > $signed({8'b0, ONE_Q30})) begin
      a_next = ONE_Q30;
    end else begin
      a_next = asum[30:0];
    end
  end

  // clamp vectoring angle to [0, 90 deg], then double
  always_comb begin
    zz = {{(ANG_W-Z_W){cz_res[Z_W-1]}}, cz_res};
    if (zz[ANG_W-1]) begin
      zc = '0;
    end else if (zz > QUARTER_TURN) begin
      zc = QUARTER_TURN;
    end else begin
      zc = zz;
    end
    ang_next = {zc[29:0], 1'b0};
  end

  // operand muxes
  always_comb begin
    cx_init = CORDIC_GAIN;
    cy_init = '0;
    cz_init = '0;
    ma = c1;
    mb = c2;
    unique case (state)
      S_SIN_LAT: cz_init = z_lat_half;
      S_SIN_LON: cz_init = z_lon_half;
      S_COS_C:   cz_init = fold_c.ang;
      S_COS_P:   cz_init = fold_p.ang;
      S_VEC: begin
        cx_init = {{(XY_W-ROOT_W){1'b0}}, sb};
        cy_init = {{(XY_W-ROOT_W){1'b0}}, sa};
      end
      S_MUL_S1: begin
        ma = s1;
        mb = s1;
      end
      S_MUL_S2: begin
        ma = s2;
        mb = s2;
      end
      S_MUL_A: begin
        ma = cc;
        mb = s2sq;
      end
      S_MUL_M: begin
        ma = {{(MUL_W-31){1'b0}}, ang};
        mb = METRE_NUM;
      end
      default: ;
    endcase
    sqrt_rad = (state == S_SQRT_A) ? a_val : (ONE_Q30 - a_val);
  end

  // successor in the fixed sequence
  always_comb begin
    unique case (state)
      S_IDLE:    succ = S_SIN_LAT;
      S_SIN_LAT: succ = S_SIN_LON;
      S_SIN_LON: succ = S_COS_C;
      S_COS_C:   succ = S_COS_P;
      S_COS_P:   succ = S_MUL_CC;
      S_MUL_CC:  succ = S_MUL_S1;
      S_MUL_S1:  succ = S_MUL_S2;
      S_MUL_S2:  succ = S_MUL_A;
      S_MUL_A:   succ = S_SQRT_A;
      S_SQRT_A:  succ = S_SQRT_B;
      S_SQRT_B:  succ = S_VEC;
      S_VEC:     succ = S_MUL_M;
      S_MUL_M:   succ = S_DIV;
      S_DIV:     succ = S_OUT;
      S_OUT:     succ = S_IDLE;
      default:   succ = S_IDLE;
    endcase
  end

  // next state and unit strobes: launch once per state, move on at done
  always_comb begin
    state_next    = state;
    launched_next = launched;
    cordic_ctl    = '0;
    mul_start     = 1'b0;
    sqrt_start    = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = succ;
        end
      end
      S_SIN_LAT, S_SIN_LON, S_COS_C, S_COS_P, S_VEC: begin
        cordic_ctl.vectoring = (state == S_VEC);
        if (!launched) begin
          cordic_ctl.start = 1'b1;
          launched_next = 1'b1;
        end else if (cordic_done) begin
          launched_next = 1'b0;
          state_next = succ;
        end
      end
      S_MUL_CC, S_MUL_S1, S_MUL_S2, S_MUL_A, S_MUL_M: begin
        if (!launched) begin
          mul_start = 1'b1;
          launched_next = 1'b1;
        end else if (mul_done) begin
          launched_next = 1'b0;
          state_next = succ;
        end
      end
      S_SQRT_A, S_SQRT_B: begin
        if (!launched) begin
          sqrt_start = 1'b1;
          launched_next = 1'b1;
        end else if (sqrt_done) begin
          launched_next = 1'b0;
          state_next = succ;
        end
      end
      S_DIV: begin
        if (!launched) begin
          div_start = 1'b1;
          launched_next = 1'b1;
        end else if (div_done) begin
          launched_next = 1'b0;
          state_next = succ;
        end
      end
      S_OUT: begin
        if (!out_valid || !out_stall) begin
          out_load = 1'b1;
          state_next = succ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      launched       <= 1'b0;
      out_valid      <= 1'b0;
      admitted_count <= '0;
      clat           <= CENTER_LAT_RST;
      clon           <= CENTER_LON_RST;
      radius         <= RADIUS_RST;
    end else begin
      state    <= state_next;
      launched <= launched_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (out_load && dist_m <= radius && admitted_count < CAP_W'(CAPACITY)) begin
        admitted_count <= admitted_count + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_CENTER_LAT: clat   <= cfg_data[30:0];
          CFG_CENTER_LON: clon   <= cfg_data;
          CFG_RADIUS:     radius <= cfg_data[DIST_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath captures
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      plat <= in_data.point_latitude;
      plon <= in_data.point_longitude;
    end
    if (cordic_done) begin
      unique case (state)
        S_SIN_LAT: s1  <= cy_res;
        S_SIN_LON: s2  <= cy_res;
        S_COS_C:   c1  <= fold_c.neg ? -cx_res : cx_res;
        S_COS_P:   c2  <= fold_p.neg ? -cx_res : cx_res;
        S_VEC:     ang <= ang_next;
        default: ;
      endcase
    end
    if (mul_done) begin
      unique case (state)
        S_MUL_CC: cc       <= r30[XY_W-1:0];
        S_MUL_S1: s1sq     <= r30[XY_W-1:0];
        S_MUL_S2: s2sq     <= r30[XY_W-1:0];
        S_MUL_A:  a_val    <= a_next;
        S_MUL_M:  dividend <= mul_prod[ACC_W-1:0] + HALF_DEN;
        default: ;
      endcase
    end
    if (sqrt_done) begin
      if (state == S_SQRT_A) begin
        sa <= sqrt_root;
      end else begin
        sb <= sqrt_root;
      end
    end
    if (div_done) begin
      dist_m <= (div_quot > MAX_DIST) ? MAX_DIST : div_quot;
    end
    if (out_load) begin
      out_data.distance_metres <= dist_m;
      out_data.within_radius   <= (dist_m <= radius);
      out_data.store_full      <= (admitted_count >= CAP_W'(CAPACITY));
      out_data.admitted        <= (dist_m <= radius) &&
                                  (admitted_count < CAP_W'(CAPACITY));
    end
  end

  hga_cordic u_cordic (
    .clk    (clk),
    .rst    (rst),
    .ctl    (cordic_ctl),
    .x_init (cx_init),
    .y_init (cy_init),
    .z_init (cz_init),
    .done   (cordic_done),
    .x_res  (cx_res),
    .y_res  (cy_res),
    .z_res  (cz_res)
  );

  hga_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a_in  (ma),
    .b_in  (mb),
    .done  (mul_done),
    .prod  (mul_prod),
    .neg   (mul_neg)
  );

  hga_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .rad   (sqrt_rad),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  hga_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .done     (div_done),
    .quot     (div_quot)
  );

  // checks
  a_admit_needs_within: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.admitted || out_data.within_radius))
    else $error("admitted word outside radius");

  a_full_blocks_admit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.admitted && out_data.store_full))
    else $error("admitted while store full");

  a_dist_saturated: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.distance_metres <= MAX_DIST))
    else $error("distance above half circumference");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    admitted_count <= CAP_W'(CAPACITY))
    else $error("admitted count beyond capacity");

endmodule
